// ----- rtl/imhtu_pkg.sv -----
// Package for the indexed min-heap timer unit.
// Holds field widths, request and status codes, the state type and shared helpers.
// No dependencies.
package imhtu_pkg;

    localparam int DEFAULT_CAPACITY = 32;
    localparam int DEFAULT_ID_COUNT = 1024;

    localparam int REQ_W     = 2;
    localparam int ID_W      = 10;
    localparam int TIMEOUT_W = 24;
    localparam int TIME_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 6;
    localparam int ID_SPACE  = 1 << ID_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_LOOK,
        S_VER,
        S_LD,
        S_DRD,
        S_DCMP,
        S_URD,
        S_UCMP,
        S_FIN,
        S_TRD,
        S_TCHK,
        S_EMIT
    } t_state;

    // One heap slot: expiry time and the id of the timer that owns it.
    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [ID_W-1:0]   owner;
    } t_node;

    typedef struct packed {
        t_status            status;
        logic               expired_valid;
        logic [ID_W-1:0]    expired_id;
        logic [TIME_W-1:0]  next_wait_ms;
        logic [COUNT_W-1:0] entry_count;
        logic               is_last;
    } t_result;

    // Wrapping comparison: a is earlier than b when a - b is negative.
    function automatic logic earlier(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return diff[TIME_W-1];
    endfunction

endpackage

// ----- rtl/imhtu_if.sv -----
// Handshake interfaces for request and result transactions.
// Depends on imhtu_pkg for field widths.
interface imhtu_req_if;
    logic                            valid;
    logic                            ready;
    logic [imhtu_pkg::REQ_W-1:0]     req_type;
    logic [imhtu_pkg::ID_W-1:0]      timer_id;
    logic [imhtu_pkg::TIMEOUT_W-1:0] timeout_ms;
    logic [imhtu_pkg::TIME_W-1:0]    now_ms;

    modport source (output valid, req_type, timer_id, timeout_ms, now_ms, input ready);
    modport sink   (input valid, req_type, timer_id, timeout_ms, now_ms, output ready);
endinterface

interface imhtu_res_if;
    logic                                valid;
    logic                                ready;
    logic [imhtu_pkg::STATUS_W-1:0]      status;
    logic                                expired_valid;
    logic [imhtu_pkg::ID_W-1:0]          expired_id;
    logic signed [imhtu_pkg::TIME_W-1:0] next_wait_ms;
    logic [imhtu_pkg::COUNT_W-1:0]       entry_count;
    logic                                is_last;

    modport source (output valid, status, expired_valid, expired_id, next_wait_ms,
                    entry_count, is_last, input ready);
    modport sink   (input valid, status, expired_valid, expired_id, next_wait_ms,
                    entry_count, is_last, output ready);
endinterface

// ----- rtl/imhtu_heap_mem.sv -----
// Heap storage: one write port and two registered read ports sharing an enable.
// Depends on imhtu_pkg for the node type.
module imhtu_heap_mem #(
    parameter int CAPACITY = imhtu_pkg::DEFAULT_CAPACITY,
    parameter int IW       = $clog2(CAPACITY)
) (
    input  logic                 i_clk,
    input  logic                 i_re,
    input  logic [IW-1:0]        i_ra0,
    input  logic [IW-1:0]        i_ra1,
    output imhtu_pkg::t_node     o_rd0,
    output imhtu_pkg::t_node     o_rd1,
    input  logic                 i_we,
    input  logic [IW-1:0]        i_wa,
    input  imhtu_pkg::t_node     i_wd
);
    imhtu_pkg::t_node r_mem [CAPACITY];
    imhtu_pkg::t_node r_rd0;
    imhtu_pkg::t_node r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd0 <= r_mem[i_ra0];
            r_rd1 <= r_mem[i_ra1];
        end
    end

    assign o_rd0 = r_rd0;
    assign o_rd1 = r_rd1;
endmodule

// ----- rtl/imhtu_slot_mem.sv -----
// Map from timer id to heap slot: one write port, one registered read port.
// Depends on nothing outside its parameters.
module imhtu_slot_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int IW    = 5
) (
    input  logic          i_clk,
    input  logic          i_re,
    input  logic [AW-1:0] i_ra,
    output logic [IW-1:0] o_rd,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [IW-1:0] i_wd
);
    logic [IW-1:0] r_mem [DEPTH];
    logic [IW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;
endmodule

// ----- rtl/indexed_min_heap_timer_unit.sv -----
// Indexed min-heap timer unit: one request at a time, ready only when idle.
// An id out of range goes straight to its result; other adds and cancels look up the slot, verify
// it and, unless refused or cancelling the last slot, sift the node through the heap before the final write.
// A tick emits one transaction per expired timer at the root, sifting after each, then a final one;
// a stalled sink holds the unit in its emit state, and ready returns with the valid of a final result.
// After reset all min(ID_COUNT,1024) id map entries are swept to zero; heap count resets to zero.
module indexed_min_heap_timer_unit #(
    parameter int CAPACITY = imhtu_pkg::DEFAULT_CAPACITY,
    parameter int ID_COUNT = imhtu_pkg::DEFAULT_ID_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    imhtu_req_if.sink   i_req,
    imhtu_res_if.source o_res
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = IW + 2;
    localparam int SLOT_DEPTH = (ID_COUNT < imhtu_pkg::ID_SPACE) ? ID_COUNT
                                                                 : imhtu_pkg::ID_SPACE;
    localparam int SAW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int TW = imhtu_pkg::TIME_W;

    imhtu_pkg::t_state  r_state, n_state, r_ret, n_ret;
    imhtu_pkg::t_req    r_req, n_req;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_n, n_n;
    logic [IW-1:0]      r_i, n_i;
    logic [IW-1:0]      r_slot, n_slot;
    logic [imhtu_pkg::ID_W-1:0] r_id, n_id;
    imhtu_pkg::t_node   r_node, n_node;
    logic [TW-1:0]      r_now, n_now;
    logic               r_moved, n_moved;
    logic [SAW:0]       r_clr, n_clr;
    imhtu_pkg::t_result r_pend, n_pend;
    imhtu_pkg::t_result r_out, n_out;
    logic               r_ov, n_ov;

    logic                  h_re, h_we, s_re, s_we;
    logic [IW-1:0]         h_ra0, h_ra1, h_wa;
    imhtu_pkg::t_node      h_rd0, h_rd1, h_wd;
    logic [SAW-1:0]        s_ra, s_wa;
    logic [IW-1:0]         s_rd, s_wd;

    imhtu_heap_mem #(.CAPACITY(CAPACITY), .IW(IW)) u_heap (
        .i_clk(i_clk), .i_re(h_re), .i_ra0(h_ra0), .i_ra1(h_ra1),
        .o_rd0(h_rd0), .o_rd1(h_rd1), .i_we(h_we), .i_wa(h_wa), .i_wd(h_wd)
    );

    imhtu_slot_mem #(.DEPTH(SLOT_DEPTH), .AW(SAW), .IW(IW)) u_slot (
        .i_clk(i_clk), .i_re(s_re), .i_ra(s_ra), .o_rd(s_rd),
        .i_we(s_we), .i_wa(s_wa), .i_wd(s_wd)
    );

    // Shared decisions.
    logic          w_accept, w_out_free, w_in_range, w_held, w_full;
    logic [XW-1:0] w_lc, w_rc, w_nx;
    logic          w_has_l, w_has_r, w_pick_r, w_stop_dn, w_stop_up;
    imhtu_pkg::t_node w_child;
    logic [IW-1:0] w_child_i, w_pm1, w_par, w_last;
    logic [TW-1:0] w_diff;
    logic          w_expired, w_more;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_ov || o_res.ready;
    assign w_in_range = {{(32-imhtu_pkg::ID_W){1'b0}}, i_req.timer_id} < 32'(ID_COUNT);
    // An id is held when its slot is live and that slot names it as owner.
    assign w_held     = (CW'(r_slot) < r_cnt) && (h_rd0.owner == r_id);
    assign w_full     = r_cnt >= CW'(CAPACITY);
    assign w_lc       = {1'b0, r_i, 1'b1};
    assign w_rc       = w_lc + XW'(1);
    assign w_nx       = XW'(r_n);
    assign w_has_l    = w_lc < w_nx;
    assign w_has_r    = w_rc < w_nx;
    assign w_pick_r   = w_has_r && imhtu_pkg::earlier(h_rd1.expiry, h_rd0.expiry);
    assign w_child    = w_pick_r ? h_rd1 : h_rd0;
    assign w_child_i  = w_pick_r ? w_rc[IW-1:0] : w_lc[IW-1:0];
    assign w_stop_dn  = imhtu_pkg::earlier(r_node.expiry, w_child.expiry);
    assign w_pm1      = r_i - IW'(1);
    assign w_par      = w_pm1 >> 1;
    assign w_stop_up  = imhtu_pkg::earlier(h_rd0.expiry, r_node.expiry);
    assign w_last     = IW'(r_cnt - CW'(1));
    assign w_diff     = h_rd0.expiry - r_now;
    assign w_expired  = (w_diff == '0) || w_diff[TW-1];
    assign w_more     = r_cnt > CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imhtu_pkg::S_CLR;
            r_ret   <= imhtu_pkg::S_IDLE;
            r_cnt   <= '0;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
        r_req   <= n_req;
        r_n     <= n_n;
        r_i     <= n_i;
        r_slot  <= n_slot;
        r_id    <= n_id;
        r_node  <= n_node;
        r_now   <= n_now;
        r_moved <= n_moved;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            imhtu_pkg::S_CLR: begin
                if (r_clr[SAW-1:0] == SAW'(SLOT_DEPTH - 1)) n_state = imhtu_pkg::S_IDLE;
            end
            imhtu_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (imhtu_pkg::t_req'(i_req.req_type))
                        imhtu_pkg::REQ_TICK:  n_state = imhtu_pkg::S_TRD;
                        imhtu_pkg::REQ_CLEAR: n_state = imhtu_pkg::S_EMIT;
                        default: n_state = w_in_range ? imhtu_pkg::S_LOOK : imhtu_pkg::S_EMIT;
                    endcase
                end
            end
            imhtu_pkg::S_LOOK: n_state = imhtu_pkg::S_VER;
            imhtu_pkg::S_VER: begin
                if (r_req == imhtu_pkg::REQ_ADD) begin
                    if (w_held)      n_state = imhtu_pkg::S_DRD;
                    else if (w_full) n_state = imhtu_pkg::S_EMIT;
                    else             n_state = imhtu_pkg::S_URD;
                end else begin
                    if (w_held && (r_slot < w_last)) n_state = imhtu_pkg::S_LD;
                    else                             n_state = imhtu_pkg::S_EMIT;
                end
            end
            imhtu_pkg::S_LD: n_state = imhtu_pkg::S_DRD;
            imhtu_pkg::S_DRD: begin
                if (w_has_l)      n_state = imhtu_pkg::S_DCMP;
                else if (r_moved) n_state = imhtu_pkg::S_FIN;
                else              n_state = imhtu_pkg::S_URD;
            end
            imhtu_pkg::S_DCMP: begin
                if (!w_stop_dn)   n_state = imhtu_pkg::S_DRD;
                else if (r_moved) n_state = imhtu_pkg::S_FIN;
                else              n_state = imhtu_pkg::S_URD;
            end
            imhtu_pkg::S_URD: begin
                n_state = (r_i == '0) ? imhtu_pkg::S_FIN : imhtu_pkg::S_UCMP;
            end
            imhtu_pkg::S_UCMP: begin
                n_state = w_stop_up ? imhtu_pkg::S_FIN : imhtu_pkg::S_URD;
            end
            imhtu_pkg::S_FIN: begin
                n_state = (r_req == imhtu_pkg::REQ_TICK) ? imhtu_pkg::S_TRD
                                                         : imhtu_pkg::S_EMIT;
            end
            imhtu_pkg::S_TRD: begin
                n_state = (r_cnt == '0) ? imhtu_pkg::S_EMIT : imhtu_pkg::S_TCHK;
            end
            imhtu_pkg::S_TCHK: n_state = imhtu_pkg::S_EMIT;
            imhtu_pkg::S_EMIT: begin
                if (w_out_free) n_state = r_ret;
            end
            default: n_state = imhtu_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory controls and handshake.
    always_comb begin
        n_ret   = r_ret;
        n_req   = r_req;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_i     = r_i;
        n_slot  = r_slot;
        n_id    = r_id;
        n_node  = r_node;
        n_now   = r_now;
        n_moved = r_moved;
        n_clr   = r_clr;
        n_pend  = r_pend;
        n_out   = r_out;
        n_ov    = r_ov && !o_res.ready;
        h_re    = 1'b0;
        h_ra0   = r_i;
        h_ra1   = r_i;
        h_we    = 1'b0;
        h_wa    = r_i;
        h_wd    = r_node;
        s_re    = 1'b0;
        s_ra    = i_req.timer_id[SAW-1:0];
        s_we    = 1'b0;
        s_wa    = r_node.owner[SAW-1:0];
        s_wd    = r_i;
        i_req.ready = (r_state == imhtu_pkg::S_IDLE);

        case (r_state)
            imhtu_pkg::S_CLR: begin
                s_we  = 1'b1;
                s_wa  = r_clr[SAW-1:0];
                s_wd  = '0;
                n_clr = r_clr + (SAW+1)'(1);
            end
            imhtu_pkg::S_IDLE: begin
                n_req         = imhtu_pkg::t_req'(i_req.req_type);
                n_id          = i_req.timer_id;
                n_now         = i_req.now_ms;
                n_node.expiry = i_req.now_ms + TW'(i_req.timeout_ms);
                n_node.owner  = i_req.timer_id;
                n_ret         = imhtu_pkg::S_IDLE;
                n_pend        = '0;
                n_pend.is_last = 1'b1;
                s_re          = w_accept;
                if (w_accept && (i_req.req_type == imhtu_pkg::REQ_CLEAR)) n_cnt = '0;
                if (!w_in_range && (i_req.req_type != imhtu_pkg::REQ_CLEAR)) begin
                    n_pend.status = imhtu_pkg::ST_NOT_FOUND;
                end
            end
            imhtu_pkg::S_LOOK: begin
                n_slot = s_rd;
                h_re   = 1'b1;
                h_ra0  = s_rd;
            end
            imhtu_pkg::S_VER: begin
                n_moved = 1'b0;
                if (r_req == imhtu_pkg::REQ_ADD) begin
                    if (w_held) begin
                        n_i = r_slot;
                        n_n = r_cnt;
                    end else if (w_full) begin
                        n_pend.status = imhtu_pkg::ST_FULL;
                    end else begin
                        n_i   = IW'(r_cnt);
                        n_cnt = r_cnt + CW'(1);
                        n_n   = r_cnt + CW'(1);
                    end
                end else if (!w_held) begin
                    n_pend.status = imhtu_pkg::ST_NOT_FOUND;
                end else begin
                    // The last slot fills the hole left by the cancelled timer.
                    n_cnt = r_cnt - CW'(1);
                    n_n   = r_cnt - CW'(1);
                    n_i   = r_slot;
                    h_re  = 1'b1;
                    h_ra0 = w_last;
                end
            end
            imhtu_pkg::S_LD: begin
                n_node  = h_rd0;
                n_moved = 1'b0;
            end
            imhtu_pkg::S_DRD: begin
                h_re  = w_has_l;
                h_ra0 = w_lc[IW-1:0];
                h_ra1 = w_rc[IW-1:0];
            end
            imhtu_pkg::S_DCMP: begin
                if (!w_stop_dn) begin
                    h_we    = 1'b1;
                    h_wd    = w_child;
                    s_we    = 1'b1;
                    s_wa    = w_child.owner[SAW-1:0];
                    n_i     = w_child_i;
                    n_moved = 1'b1;
                end
            end
            imhtu_pkg::S_URD: begin
                h_re  = (r_i != '0);
                h_ra0 = w_par;
            end
            imhtu_pkg::S_UCMP: begin
                if (!w_stop_up) begin
                    h_we = 1'b1;
                    h_wd = h_rd0;
                    s_we = 1'b1;
                    s_wa = h_rd0.owner[SAW-1:0];
                    n_i  = w_par;
                end
            end
            imhtu_pkg::S_FIN: begin
                h_we = 1'b1;
                s_we = 1'b1;
            end
            imhtu_pkg::S_TRD: begin
                h_re  = 1'b1;
                h_ra0 = '0;
                n_ret = imhtu_pkg::S_IDLE;
                n_pend = '0;
                n_pend.is_last      = 1'b1;
                n_pend.next_wait_ms = '1;
            end
            imhtu_pkg::S_TCHK: begin
                n_pend = '0;
                if (!w_expired) begin
                    n_pend.is_last      = 1'b1;
                    n_pend.next_wait_ms = w_diff;
                    n_ret               = imhtu_pkg::S_IDLE;
                end else begin
                    n_pend.expired_valid = 1'b1;
                    n_pend.expired_id    = h_rd0.owner;
                    n_cnt                = r_cnt - CW'(1);
                    if (w_more) begin
                        // Move the last node to the root and sift it down after the emit.
                        n_i   = '0;
                        n_n   = r_cnt - CW'(1);
                        h_re  = 1'b1;
                        h_ra0 = w_last;
                        n_ret = imhtu_pkg::S_LD;
                    end else begin
                        n_ret = imhtu_pkg::S_TRD;
                    end
                end
            end
            imhtu_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_ov              = 1'b1;
                    n_out             = r_pend;
                    n_out.entry_count = imhtu_pkg::COUNT_W'(r_cnt);
                end
            end
            default: ;
        endcase
    end

    assign o_res.valid         = r_ov;
    assign o_res.status        = r_out.status;
    assign o_res.expired_valid = r_out.expired_valid;
    assign o_res.expired_id    = r_out.expired_id;
    assign o_res.next_wait_ms  = r_out.next_wait_ms;
    assign o_res.entry_count   = r_out.entry_count;
    assign o_res.is_last       = r_out.is_last;
endmodule

// ----- rtl/imhtu_checker.sv -----
// Port-level checks for the indexed min-heap timer unit, bound to the top level.
// Depends on imhtu_pkg for widths and status codes.
module imhtu_checker #(
    parameter int CAPACITY = imhtu_pkg::DEFAULT_CAPACITY
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                i_ready,
    input logic [imhtu_pkg::STATUS_W-1:0]      i_status,
    input logic                                i_expired_valid,
    input logic signed [imhtu_pkg::TIME_W-1:0] i_next_wait_ms,
    input logic [imhtu_pkg::COUNT_W-1:0]       i_entry_count,
    input logic                                i_is_last
);
    // A stalled transaction stays valid and keeps its entry count and last flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_entry_count) && $stable(i_is_last))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_entry_count <= imhtu_pkg::COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // An expired-timer transaction is never the last one and always reports ok.
    a_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_expired_valid |-> !i_is_last && i_status == imhtu_pkg::ST_OK)
        else $error("bad expired transaction");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_expired_valid || i_is_last)
        else $error("transaction is neither expiry nor final");

    a_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_is_last |-> i_next_wait_ms == '0)
        else $error("wait reported on a non-final transaction");
endmodule

bind indexed_min_heap_timer_unit imhtu_checker #(.CAPACITY(CAPACITY)) u_imhtu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_status       (o_res.status),
    .i_expired_valid(o_res.expired_valid),
    .i_next_wait_ms (o_res.next_wait_ms),
    .i_entry_count  (o_res.entry_count),
    .i_is_last      (o_res.is_last)
);

// ----- tb/tb.sv -----
// Testbench for the indexed min-heap timer unit: directed and random request traffic checked
// against a behavioral heap model kept in a small scoreboard class.
// Depends on imhtu_pkg, imhtu_if and the indexed_min_heap_timer_unit RTL.
`timescale 1ns / 100ps

module tb;
    localparam int CAP = imhtu_pkg::DEFAULT_CAPACITY;
    localparam int IDS = imhtu_pkg::DEFAULT_ID_COUNT;
    localparam int TW  = imhtu_pkg::TIME_W;
    localparam int IDW = imhtu_pkg::ID_W;
    localparam int TMW = imhtu_pkg::TIMEOUT_W;
    localparam int CNW = imhtu_pkg::COUNT_W;

    class timer_heap_sb;
        logic [TW-1:0]      expiry_q[CAP];
        logic [IDW-1:0]     owner_q[CAP];
        int                 slot_q[IDS];
        bit                 held_q[IDS];
        int                 count;
        imhtu_pkg::t_result pending[$];
        int                 errors;

        function new();
            count = 0;
            errors = 0;
            foreach (held_q[k]) held_q[k] = 0;
        endfunction

        function bit is_earlier(logic [TW-1:0] a, logic [TW-1:0] b);
            logic [TW-1:0] d;
            d = a - b;
            return d[TW-1];
        endfunction

        function void swap_nodes(int i, int j);
            logic [TW-1:0]  e;
            logic [IDW-1:0] o;
            e = expiry_q[i]; o = owner_q[i];
            expiry_q[i] = expiry_q[j]; owner_q[i] = owner_q[j];
            expiry_q[j] = e; owner_q[j] = o;
            slot_q[owner_q[i]] = i;
            slot_q[owner_q[j]] = j;
        endfunction

        function void bubble_up(int i);
            int p;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (is_earlier(expiry_q[p], expiry_q[i])) break;
                swap_nodes(i, p);
                i = p;
            end
        endfunction

        function bit push_down(int start, int n);
            int i;
            int c;
            i = start;
            c = 2 * i + 1;
            while (c < n) begin
                if (c + 1 < n && is_earlier(expiry_q[c+1], expiry_q[c])) c++;
                if (is_earlier(expiry_q[i], expiry_q[c])) break;
                swap_nodes(i, c);
                i = c;
                c = 2 * i + 1;
            end
            return i > start;
        endfunction

        function void drop_slot(int i);
            int last;
            last = count - 1;
            if (i < last) begin
                swap_nodes(i, last);
                if (!push_down(i, last)) bubble_up(i);
            end
            held_q[owner_q[last]] = 0;
            count = last;
        endfunction

        function void queue_result(imhtu_pkg::t_status st, logic ev, logic [IDW-1:0] eid,
                                   logic [TW-1:0] w, logic last);
            imhtu_pkg::t_result r;
            r.status = st;
            r.expired_valid = ev;
            r.expired_id = eid;
            r.next_wait_ms = w;
            r.entry_count = count[CNW-1:0];
            r.is_last = last;
            pending = {pending, r};
        endfunction

        // Applies one accepted request and queues every result it causes.
        function void note_request(imhtu_pkg::t_req rq, logic [IDW-1:0] id,
                                   logic [TMW-1:0] tmo, logic [TW-1:0] now);
            imhtu_pkg::t_status st;
            logic [TW-1:0] d;
            logic [IDW-1:0] own;
            int i;
            st = imhtu_pkg::ST_OK;
            case (rq)
                imhtu_pkg::REQ_ADD: begin
                    if (held_q[id]) begin
                        i = slot_q[id];
                        expiry_q[i] = now + TW'(tmo);
                        if (!push_down(i, count)) bubble_up(i);
                    end else if (count >= CAP) begin
                        st = imhtu_pkg::ST_FULL;
                    end else begin
                        i = count;
                        expiry_q[i] = now + TW'(tmo);
                        owner_q[i] = id;
                        slot_q[id] = i;
                        held_q[id] = 1;
                        count = i + 1;
                        bubble_up(i);
                    end
                    queue_result(st, 0, '0, '0, 1);
                end
                imhtu_pkg::REQ_CANCEL: begin
                    if (!held_q[id]) st = imhtu_pkg::ST_NOT_FOUND;
                    else drop_slot(slot_q[id]);
                    queue_result(st, 0, '0, '0, 1);
                end
                imhtu_pkg::REQ_TICK: begin
                    while (count > 0) begin
                        d = expiry_q[0] - now;
                        if (d != 0 && !d[TW-1]) break;
                        own = owner_q[0];
                        drop_slot(0);
                        queue_result(imhtu_pkg::ST_OK, 1, own, '0, 0);
                    end
                    queue_result(imhtu_pkg::ST_OK, 0, '0,
                                 count > 0 ? expiry_q[0] - now : '1, 1);
                end
                default: begin
                    foreach (held_q[k]) held_q[k] = 0;
                    count = 0;
                    queue_result(imhtu_pkg::ST_OK, 0, '0, '0, 1);
                end
            endcase
        endfunction

        function void check_result(imhtu_pkg::t_result act);
            imhtu_pkg::t_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, act);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (act.status !== exp_r.status)
                $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, act.status);
            if (act.expired_valid !== exp_r.expired_valid)
                $display("%0t: expired_valid exp %0b got %0b", $realtime,
                         exp_r.expired_valid, act.expired_valid);
            if (act.expired_id !== exp_r.expired_id)
                $display("%0t: expired_id exp %0d got %0d", $realtime,
                         exp_r.expired_id, act.expired_id);
            if (act.next_wait_ms !== exp_r.next_wait_ms)
                $display("%0t: next_wait_ms exp %h got %h", $realtime,
                         exp_r.next_wait_ms, act.next_wait_ms);
            if (act.entry_count !== exp_r.entry_count)
                $display("%0t: entry_count exp %0d got %0d", $realtime,
                         exp_r.entry_count, act.entry_count);
            if (act.is_last !== exp_r.is_last)
                $display("%0t: is_last exp %0b got %0b", $realtime,
                         exp_r.is_last, act.is_last);
            if (act !== exp_r) errors++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    imhtu_req_if req_bus ();
    imhtu_res_if res_bus ();
    timer_heap_sb timer_sb;
    logic [TW-1:0] clock_ms;
    int burst_left;

    indexed_min_heap_timer_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus.sink),
        .o_res  (res_bus.source)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stalls follow a mode that changes now and then: always ready,
    // light random stalls, or long stretches of heavy stalls.
    int stall_mode;
    always @(posedge i_clk) begin
        imhtu_pkg::t_result r;
        if (res_bus.valid && res_bus.ready && i_rst_n) begin
            r.status = imhtu_pkg::t_status'(res_bus.status);
            r.expired_valid = res_bus.expired_valid;
            r.expired_id = res_bus.expired_id;
            r.next_wait_ms = res_bus.next_wait_ms;
            r.entry_count = res_bus.entry_count;
            r.is_last = res_bus.is_last;
            timer_sb.check_result(r);
        end
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: res_bus.ready <= 1'b1;
            1: res_bus.ready <= ($urandom_range(0, 3) != 0);
            default: res_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Drives one request and holds it until the block takes it. Bursts of
    // back-to-back transactions alternate with random gaps.
    task automatic send_request(imhtu_pkg::t_req rq, logic [IDW-1:0] id,
                                logic [TMW-1:0] tmo, logic [TW-1:0] now);
        if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        req_bus.valid <= 1'b1;
        req_bus.req_type <= rq;
        req_bus.timer_id <= id;
        req_bus.timeout_ms <= tmo;
        req_bus.now_ms <= now;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        timer_sb.note_request(rq, id, tmo, now);
        burst_left--;
        if (burst_left == 0) req_bus.valid <= 1'b0;
    endtask

    task automatic drain_results();
        req_bus.valid <= 1'b0;
        burst_left = 0;
        while (timer_sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Most ids come from a small pool so refreshes, cancels and expiries collide.
    function automatic logic [IDW-1:0] pick_id();
        if ($urandom_range(0, 9) == 0) return IDW'($urandom_range(0, IDS - 1));
        return IDW'($urandom_range(0, 47));
    endfunction

    function automatic logic [TMW-1:0] pick_timeout();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return TMW'($urandom);
            default: return TMW'($urandom_range(0, 400));
        endcase
    endfunction

    initial begin
        int roll;
        timer_sb = new();
        i_rst_n = 0;
        burst_left = 0;
        req_bus.valid = 0;
        req_bus.req_type = imhtu_pkg::REQ_ADD;
        req_bus.timer_id = '0;
        req_bus.timeout_ms = '0;
        req_bus.now_ms = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty tick, unknown cancel, extremes of every field,
        // equal expiries, refresh, wrap of the time base and clear.
        send_request(imhtu_pkg::REQ_TICK, '0, '0, '1);
        send_request(imhtu_pkg::REQ_CANCEL, 10'd1023, '0, '0);
        send_request(imhtu_pkg::REQ_ADD, 10'd1023, '1, 32'hFFFF_FFF0);
        send_request(imhtu_pkg::REQ_ADD, 10'd0, 24'd0, 32'hFFFF_FFF0);
        send_request(imhtu_pkg::REQ_ADD, 10'd5, 24'd20, 32'hFFFF_FFF0);
        send_request(imhtu_pkg::REQ_ADD, 10'd6, 24'd20, 32'hFFFF_FFF0);
        send_request(imhtu_pkg::REQ_ADD, 10'd7, 24'd20, 32'hFFFF_FFF0);
        send_request(imhtu_pkg::REQ_ADD, 10'd5, 24'd2, 32'hFFFF_FFF0);
        send_request(imhtu_pkg::REQ_TICK, '0, '0, 32'h0000_0004);
        send_request(imhtu_pkg::REQ_CANCEL, 10'd7, '0, '0);
        send_request(imhtu_pkg::REQ_CANCEL, 10'd7, '0, '0);
        send_request(imhtu_pkg::REQ_TICK, '0, '0, 32'h8000_0000);
        send_request(imhtu_pkg::REQ_CLEAR, 10'h2AA, 24'h555555, 32'h5555_5555);
        send_request(imhtu_pkg::REQ_TICK, 10'h155, 24'hAAAAAA, 32'hAAAA_AAAA);
        // Fill the heap, then overflow it and refresh a held id while full.
        for (int k = 0; k < CAP; k++)
            send_request(imhtu_pkg::REQ_ADD, k[IDW-1:0] + 10'd100, 24'(k % 3), 32'd1000);
        send_request(imhtu_pkg::REQ_ADD, 10'd900, 24'd1, 32'd1000);
        send_request(imhtu_pkg::REQ_ADD, 10'd110, 24'd0, 32'd1000);
        send_request(imhtu_pkg::REQ_TICK, '0, '0, 32'd1001);
        send_request(imhtu_pkg::REQ_TICK, '0, '0, 32'd1002);
        drain_results();

        clock_ms = $urandom;
        for (int n = 0; n < 500; n++) begin
            if (n == 250) drain_results();
            clock_ms += $urandom_range(0, 60);
            roll = $urandom_range(0, 99);
            if (roll < 50)
                send_request(imhtu_pkg::REQ_ADD, pick_id(), pick_timeout(), clock_ms);
            else if (roll < 70)
                send_request(imhtu_pkg::REQ_CANCEL, pick_id(), pick_timeout(), $urandom);
            else if (roll < 97)
                send_request(imhtu_pkg::REQ_TICK, pick_id(), TMW'($urandom), clock_ms);
            else
                send_request(imhtu_pkg::REQ_CLEAR, pick_id(), TMW'($urandom), $urandom);
        end
        drain_results();
        repeat (100) @(posedge i_clk);
        if (timer_sb.errors == 0 && timer_sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
